@@ design/ole_pkg.sv @@
// ----------------------------------------------------------------------------
// ole_pkg: shared types and codes of the ordered list engine
// Request and status codes, the cell operation and the control word that the
// sequencer broadcasts along the row of storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ole_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned LenW  = 7;
  localparam int unsigned PosW  = 8;
  localparam int unsigned ReqW  = 3;
  localparam int unsigned StatW = 2;

  // Request codes.
  localparam logic [ReqW-1:0] REQ_APPEND    = 3'd0;
  localparam logic [ReqW-1:0] REQ_DEL_FRONT = 3'd1;
  localparam logic [ReqW-1:0] REQ_DEL_BACK  = 3'd2;
  localparam logic [ReqW-1:0] REQ_DEL_POS   = 3'd3;
  localparam logic [ReqW-1:0] REQ_DUMP      = 3'd4;

  // Status codes.
  localparam logic [StatW-1:0] STAT_OK     = 2'd0;
  localparam logic [StatW-1:0] STAT_EMPTY  = 2'd1;
  localparam logic [StatW-1:0] STAT_BADPOS = 2'd2;
  localparam logic [StatW-1:0] STAT_FULL   = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT,
    CELL_ROTATE
  } cell_op_e;

  // Control word seen by every cell in the same cycle.
  typedef struct packed {
    cell_op_e               op;
    logic [LenW-1:0]        idx;   // target cell of a load, first cell of a shift
    logic [LenW-1:0]        cnt;   // current length, bounds a rotation
    logic signed [DataW-1:0] data; // word written by a load
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ design/ole_cell.sv @@
// ----------------------------------------------------------------------------
// ole_cell: one storage cell of the list row
// Holds one word; loads, takes its right neighbor's word, or wraps the head
// word around during a rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                               clk_i,
  input  wire ole_pkg::cell_ctrl_t                ctrl_i,
  input  wire logic signed [ole_pkg::DataW-1:0]   next_i,
  input  wire logic signed [ole_pkg::DataW-1:0]   head_i,
  output logic signed [ole_pkg::DataW-1:0]        data_o
);
  import ole_pkg::*;

  localparam logic [LenW-1:0] MyIdx  = LenW'(IDX);
  localparam logic [LenW-1:0] MyIdx1 = LenW'(IDX + 1);

  logic signed [DataW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_LOAD: begin
        if (ctrl_i.idx == MyIdx) data_d = ctrl_i.data;
      end
      CELL_SHIFT: begin
        if (MyIdx >= ctrl_i.idx) data_d = next_i;
      end
      CELL_ROTATE: begin
        // The occupied cells turn as a ring; the tail cell takes the head.
        if (MyIdx1 < ctrl_i.cnt) begin
          data_d = next_i;
        end else if (MyIdx1 == ctrl_i.cnt) begin
          data_d = head_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

@@ design/ordered_list_engine.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine: bounded ordered list of signed 32-bit words
// Append, delete front, delete back, delete at a 1-based position and dump,
// kept in a row of cells that shift together to close a gap.
// ----------------------------------------------------------------------------
// Timing: a single-result request is registered and shown on the master side
//   in the cycle after it is accepted; a new request waits while the output
//   word is held back. A dump of a non-empty list holds off new requests until
//   its last word is emitted; the cell row turns by one cell per emitted word.
// Reset: rst_ni clears the length, the sequencer and the output valid flag;
//   cell contents are not reset and are only read below the stored length.
`default_nettype none

module ordered_list_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata, lowest bit up: value[31:0], position[39:32]
  input  wire logic [39:0] s_axis_tdata_i,
  // tuser: req_type[2:0]
  input  wire logic [2:0]  s_axis_tuser_i,

  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // tdata, lowest bit up: element[31:0], length[38:32], zero pad[39]
  output logic [39:0]      m_axis_tdata_o,
  // tuser: status[1:0]
  output logic [1:0]       m_axis_tuser_o,
  output logic             m_axis_tlast_o
);
  import ole_pkg::*;

  // The length register is sized for CAPACITY itself; the dump counter
  // only has to reach CAPACITY - 1.
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  // Input word fields.
  logic [ReqW-1:0]         req_type;
  logic signed [DataW-1:0] req_value;
  logic [PosW-1:0]         req_pos;

  assign req_type  = s_axis_tuser_i;
  assign req_value = s_axis_tdata_i[DataW-1:0];
  assign req_pos   = s_axis_tdata_i[DataW +: PosW];

  state_e                  state_q, state_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [IdxW-1:0]         dump_idx_q, dump_idx_d;
  logic                    out_valid_q, out_valid_d;
  logic [StatW-1:0]        out_status_q, out_status_d;
  logic signed [DataW-1:0] out_elem_q, out_elem_d;
  logic [LenW-1:0]         out_len_q, out_len_d;
  logic                    out_last_q, out_last_d;

  cell_ctrl_t              cell_ctrl;
  logic signed [DataW-1:0] cell_data [CAPACITY];

  logic out_free;
  logic accept;
  logic is_empty;
  logic is_full;
  logic pos_ok;
  logic dump_last;

  // The output register may be refilled in the cycle its word is taken.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign is_empty  = (count_q == '0);
  assign is_full   = (count_q == CntW'(CAPACITY));
  assign pos_ok    = (req_pos != '0) && (req_pos <= PosW'(count_q));
  assign dump_last = (dump_idx_q == IdxW'(count_q - CntW'(1)));

  // Request decode and the sequencer that walks a dump.
  always_comb begin
    logic             single;
    logic [StatW-1:0] status;

    single       = 1'b0;
    status       = STAT_OK;
    state_d      = state_q;
    count_d      = count_q;
    dump_idx_d   = dump_idx_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_elem_d   = out_elem_q;
    out_len_d    = out_len_q;
    out_last_d   = out_last_q;

    cell_ctrl.op   = CELL_HOLD;
    cell_ctrl.idx  = '0;
    cell_ctrl.cnt  = LenW'(count_q);
    cell_ctrl.data = req_value;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          single = 1'b1;
          case (req_type)
            REQ_APPEND: begin
              if (is_full) begin
                status = STAT_FULL;
              end else begin
                cell_ctrl.op  = CELL_LOAD;
                cell_ctrl.idx = LenW'(count_q);
                count_d       = count_q + CntW'(1);
              end
            end
            REQ_DEL_FRONT: begin
              if (is_empty) begin
                status = STAT_EMPTY;
              end else begin
                cell_ctrl.op  = CELL_SHIFT;
                cell_ctrl.idx = '0;
                count_d       = count_q - CntW'(1);
              end
            end
            REQ_DEL_BACK: begin
              // Dropping the tail only shortens the list.
              if (is_empty) begin
                status = STAT_EMPTY;
              end else begin
                count_d = count_q - CntW'(1);
              end
            end
            REQ_DEL_POS: begin
              if (is_empty) begin
                status = STAT_EMPTY;
              end else if (!pos_ok) begin
                status = STAT_BADPOS;
              end else begin
                cell_ctrl.op  = CELL_SHIFT;
                cell_ctrl.idx = LenW'(req_pos - PosW'(1));
                count_d       = count_q - CntW'(1);
              end
            end
            REQ_DUMP: begin
              if (is_empty) begin
                status = STAT_EMPTY;
              end else begin
                single     = 1'b0;
                state_d    = ST_DUMP;
                dump_idx_d = '0;
              end
            end
            default: status = STAT_OK;
          endcase
        end
      end

      ST_DUMP: begin
        // Cell 0 always holds the next word; the ring turns as it leaves.
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = STAT_OK;
          out_elem_d   = cell_data[0];
          out_len_d    = LenW'(count_q);
          out_last_d   = dump_last;
          cell_ctrl.op = CELL_ROTATE;
          if (dump_last) begin
            state_d = ST_IDLE;
          end else begin
            dump_idx_d = dump_idx_q + IdxW'(1);
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase

    if (single) begin
      out_valid_d  = 1'b1;
      out_status_d = status;
      out_elem_d   = '0;
      out_len_d    = LenW'(count_d);
      out_last_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      dump_idx_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= STAT_OK;
      out_elem_q   <= '0;
      out_len_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      dump_idx_q   <= dump_idx_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_elem_q   <= out_elem_d;
      out_len_q    <= out_len_d;
      out_last_q   <= out_last_d;
    end
  end

  // Row of cells; each one sees its right neighbor and the head cell.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [DataW-1:0] next_data;

    if (k == CAPACITY - 1) begin : g_tail
      assign next_data = '0;
    end else begin : g_mid
      assign next_data = cell_data[k + 1];
    end

    ole_cell #(
      .IDX (k)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl),
      .next_i (next_data),
      .head_i (cell_data[0]),
      .data_o (cell_data[k])
    );
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_len_q, out_elem_q};
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire
